FILE: rtl/bz_pkg.sv
// ----------------------------------------------------------------------------
// bz_pkg: shared types and constants for the bezier easing evaluator
// Holds field widths, sequencer state and step codes, the datapath control
// bundle and the builder for the control point conversion table.
// ----------------------------------------------------------------------------
`default_nettype none

package bz_pkg;

	localparam int unsigned DEF_ITERATIONS    = 100;
	localparam int unsigned DEF_FRACTION_BITS = 24;
	localparam int unsigned MAX_FB            = 32;

	localparam int unsigned POS_W  = 17;
	localparam int unsigned CTRL_W = 7;
	localparam int unsigned OUT_W  = 17;
	localparam int unsigned TOL_W  = 16;

	localparam logic [TOL_W-1:0] TOL_RESET = 16'd1678;
	localparam logic [OUT_W-1:0] OUT_MAX   = 17'd65536;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_DECIDE,
		ST_RESULT
	} seq_state_t;

	// one product per step, except the first which forms u = 1 - t
	typedef enum logic [3:0] {
		MS_U,
		MS_UU,
		MS_UT,
		MS_TT,
		MS_UUT,
		MS_UTT,
		MS_TTT,
		MS_A,
		MS_B
	} mul_step_t;

	typedef struct packed {
		logic      load;
		logic      mul_en;
		mul_step_t step;
		logic      sum_en;
		logic      decide_en;
		logic      final_pass;
		logic      result_en;
	} dp_ctrl_t;

	typedef logic [MAX_FB:0] ctrl_lut_t [128];

	// round(c * 2^fb / 127), evaluated at elaboration
	function automatic ctrl_lut_t build_ctrl_lut(input int unsigned fb);
		ctrl_lut_t lut;
		for (int i = 0; i < 128; i++) begin
			lut[i] = (MAX_FB + 1)'(((64'(i) << fb) + 64'd63) / 64'd127);
		end
		return lut;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/bz_if.sv
// ----------------------------------------------------------------------------
// bz_if: valid/ready channels of the bezier easing evaluator
// Item channel carries the curve position and control points, result channel
// carries the eased value.
// ----------------------------------------------------------------------------
`default_nettype none

interface bz_item_if import bz_pkg::*;;
	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  position;
	logic [CTRL_W-1:0] ctrl_one_x;
	logic [CTRL_W-1:0] ctrl_one_y;
	logic [CTRL_W-1:0] ctrl_two_x;
	logic [CTRL_W-1:0] ctrl_two_y;

	modport source (
		output valid, position, ctrl_one_x, ctrl_one_y, ctrl_two_x, ctrl_two_y,
		input  ready
	);
	modport sink (
		input  valid, position, ctrl_one_x, ctrl_one_y, ctrl_two_x, ctrl_two_y,
		output ready
	);
endinterface

interface bz_result_if import bz_pkg::*;;
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] eased_value;

	modport source (output valid, eased_value, input ready);
	modport sink (input valid, eased_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/bz_mul.sv
// ----------------------------------------------------------------------------
// bz_mul: shared fixed point multiplier
// Multiplies two unsigned Q1.F values and rounds the product back to Q1.F,
// halves rounded up.
// ----------------------------------------------------------------------------
`default_nettype none

module bz_mul import bz_pkg::*; #(
	parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic [FRACTION_BITS:0] op_a,
	input  logic [FRACTION_BITS:0] op_b,
	output logic [FRACTION_BITS:0] prod
);

	localparam int unsigned FB = FRACTION_BITS;
	localparam int unsigned VW = FB + 1;
	localparam int unsigned PW = 2 * VW;
	localparam logic [PW-1:0] HALF = (PW'(1) << FB) >> 1;

	logic [PW-1:0] full;
	logic [PW-1:0] rounded;

	assign full    = PW'(op_a) * PW'(op_b);
	assign rounded = full + HALF;
	// operands never exceed one, so the rounded product fits Q1.F
	assign prod    = rounded[FB +: VW];

endmodule

`default_nettype wire

FILE: rtl/bz_seq.sv
// ----------------------------------------------------------------------------
// bz_seq: sequencer for the bisection search
// Steps the shared multiplier through one curve evaluation, then the sum and
// the bracket decision, and finally evaluates y at the found parameter.
// ----------------------------------------------------------------------------
`default_nettype none

module bz_seq import bz_pkg::*; #(
	parameter int unsigned ITERATIONS = DEF_ITERATIONS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     stop,
	input  logic     out_free,
	output logic     idle,
	output dp_ctrl_t ctrl
);

	localparam int unsigned IW = $clog2(ITERATIONS);
	localparam logic [IW-1:0] LAST_ITER = IW'(ITERATIONS - 1);

	seq_state_t state_q, state_d;
	mul_step_t  step_q, step_nxt;
	logic [IW-1:0] iter_q;
	logic       final_q;

	always_comb begin
		case (step_q)
			MS_U:    step_nxt = MS_UU;
			MS_UU:   step_nxt = MS_UT;
			MS_UT:   step_nxt = MS_TT;
			MS_TT:   step_nxt = MS_UUT;
			MS_UUT:  step_nxt = MS_UTT;
			MS_UTT:  step_nxt = MS_TTT;
			MS_TTT:  step_nxt = MS_A;
			MS_A:    step_nxt = MS_B;
			default: step_nxt = MS_U;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (step_q == MS_B) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				state_d = final_q ? ST_RESULT : ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = ST_MUL;
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= MS_U;
			iter_q  <= '0;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL) begin
				step_q <= step_nxt;
			end else begin
				step_q <= MS_U;
			end
			if (state_q == ST_IDLE) begin
				iter_q  <= '0;
				final_q <= 1'b0;
			end else if (state_q == ST_DECIDE) begin
				iter_q <= iter_q + 1'b1;
				// tolerance met, bracket frozen or step budget spent
				if (stop || iter_q == LAST_ITER) begin
					final_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		idle            = (state_q == ST_IDLE);
		ctrl            = '0;
		ctrl.step       = step_q;
		ctrl.final_pass = final_q;
		case (state_q)
			ST_IDLE:   ctrl.load      = start;
			ST_MUL:    ctrl.mul_en    = 1'b1;
			ST_SUM:    ctrl.sum_en    = 1'b1;
			ST_DECIDE: ctrl.decide_en = !final_q;
			ST_RESULT: ctrl.result_en = out_free;
			default:   ctrl.load      = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/bz_dp.sv
// ----------------------------------------------------------------------------
// bz_dp: datapath of the bisection search
// Holds the item, the bracket (low, middle, high), the partial products of
// one curve evaluation, and forms the decision and the rounded result.
// ----------------------------------------------------------------------------
`default_nettype none

module bz_dp import bz_pkg::*; #(
	parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic              clk,
	input  dp_ctrl_t          ctrl,
	input  logic [TOL_W-1:0]  tolerance,
	input  logic [POS_W-1:0]  position,
	input  logic [CTRL_W-1:0] ctrl_one_x,
	input  logic [CTRL_W-1:0] ctrl_one_y,
	input  logic [CTRL_W-1:0] ctrl_two_x,
	input  logic [CTRL_W-1:0] ctrl_two_y,
	output logic              stop,
	output logic [OUT_W-1:0]  eased_value
);

	localparam int unsigned FB     = FRACTION_BITS;
	localparam int unsigned VW     = FB + 1;
	localparam int unsigned SW     = FB + 3;
	localparam int unsigned TOL_UP = (FB >= 24) ? FB - 24 : 0;
	localparam int unsigned TOL_DN = (FB >= 24) ? 0 : 24 - FB;
	localparam int unsigned SH     = FB - 16;

	localparam logic [VW-1:0] ONE      = VW'(1) << FB;
	localparam logic [VW-1:0] HALF_ONE = ONE >> 1;
	localparam logic [SW:0]   HALF_OUT = ((SW + 1)'(1) << SH) >> 1;
	localparam ctrl_lut_t     CTRL_LUT = build_ctrl_lut(FB);

	logic [VW-1:0] x_q, px1_q, py1_q, px2_q, py2_q;
	logic [VW-1:0] lo_q, mid_q, hi_q, lo_mid_q, hi_mid_q;
	logic [VW-1:0] u_q, uu_q, ut_q, tt_q, uut_q, utt_q, ttt_q, a_q, b_q;
	logic [SW-1:0] bm_q, bl_q;
	logic          stay_lo_q, stay_hi_q;

	logic [VW-1:0] op_a, op_b, prod, p1, p2;
	logic [VW:0]   ab, lo_sum, hi_sum;
	logic [SW-1:0] bm_sum, xw, tol, err;
	logic          early, opposite;
	logic [SW:0]   y_rnd;
	logic [SW:0]   y_sh;

	assign p1 = ctrl.final_pass ? py1_q : px1_q;
	assign p2 = ctrl.final_pass ? py2_q : px2_q;

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (ctrl.step)
			MS_UU:   begin op_a = u_q;   op_b = u_q;   end
			MS_UT:   begin op_a = u_q;   op_b = mid_q; end
			MS_TT:   begin op_a = mid_q; op_b = mid_q; end
			MS_UUT:  begin op_a = uu_q;  op_b = mid_q; end
			MS_UTT:  begin op_a = ut_q;  op_b = mid_q; end
			MS_TTT:  begin op_a = tt_q;  op_b = mid_q; end
			MS_A:    begin op_a = uut_q; op_b = p1;    end
			MS_B:    begin op_a = utt_q; op_b = p2;    end
			default: begin op_a = '0;    op_b = '0;    end
		endcase
	end

	bz_mul #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_mul (
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	// 3*(a + b) + t^3
	assign ab     = {1'b0, a_q} + {1'b0, b_q};
	assign bm_sum = SW'({ab, 1'b0}) + SW'(ab) + SW'(ttt_q);
	assign lo_sum = {1'b0, lo_q} + {1'b0, mid_q};
	assign hi_sum = {1'b0, hi_q} + {1'b0, mid_q};

	assign xw       = SW'(x_q);
	assign tol      = (SW'(tolerance) << TOL_UP) >> TOL_DN;
	assign err      = (xw >= bm_q) ? xw - bm_q : bm_q - xw;
	assign early    = err < tol;
	// keep the lower half only on a strict sign change
	assign opposite = (xw > bl_q && xw < bm_q) || (xw < bl_q && xw > bm_q);
	assign stop     = early || (opposite ? stay_lo_q : stay_hi_q);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q   <= VW'(position) << SH;
			px1_q <= CTRL_LUT[ctrl_one_x][FB:0];
			py1_q <= CTRL_LUT[ctrl_one_y][FB:0];
			px2_q <= CTRL_LUT[ctrl_two_x][FB:0];
			py2_q <= CTRL_LUT[ctrl_two_y][FB:0];
			lo_q  <= '0;
			mid_q <= HALF_ONE;
			hi_q  <= ONE;
			bl_q  <= '0;
		end
		if (ctrl.mul_en) begin
			case (ctrl.step)
				MS_U:    u_q   <= ONE - mid_q;
				MS_UU:   uu_q  <= prod;
				MS_UT:   ut_q  <= prod;
				MS_TT:   tt_q  <= prod;
				MS_UUT:  uut_q <= prod;
				MS_UTT:  utt_q <= prod;
				MS_TTT:  ttt_q <= prod;
				MS_A:    a_q   <= prod;
				MS_B:    b_q   <= prod;
				default: u_q   <= u_q;
			endcase
		end
		if (ctrl.sum_en) begin
			bm_q      <= bm_sum;
			lo_mid_q  <= lo_sum[VW:1];
			hi_mid_q  <= hi_sum[VW:1];
			// bracket would come out unchanged on that side
			stay_lo_q <= (lo_sum[VW:1] == mid_q) && (mid_q == hi_q);
			stay_hi_q <= (hi_sum[VW:1] == mid_q) && (mid_q == lo_q);
		end
		if (ctrl.decide_en && !early) begin
			if (opposite) begin
				hi_q  <= mid_q;
				mid_q <= lo_mid_q;
			end else begin
				lo_q  <= mid_q;
				mid_q <= hi_mid_q;
				bl_q  <= bm_q;
			end
		end
	end

	assign y_rnd = {1'b0, bm_q} + HALF_OUT;
	assign y_sh  = y_rnd >> SH;
	assign eased_value = (y_sh > (SW + 1)'(OUT_MAX)) ? OUT_MAX : y_sh[OUT_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/bezier_easing_bisection.sv
// ----------------------------------------------------------------------------
// bezier_easing_bisection: cubic bezier easing curve by bisection
// Each bisection step runs the shared multiplier, the sum and the decision,
//   for at most ITERATIONS steps, fewer once the x error is under tolerance
//   or the bracket stops moving; y is then evaluated at the found parameter.
// A new item is taken only once the last result is in the output register;
//   the multiplier does the eight products of each curve evaluation, one per cycle.
// Reset: arst_n clears the sequencer and result valid, tolerance to 1678.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_easing_bisection import bz_pkg::*; #(
	parameter int unsigned ITERATIONS    = DEF_ITERATIONS,
	parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [TOL_W-1:0] cfg_wdata,
	bz_item_if.sink          item,
	bz_result_if.source      result
);

	dp_ctrl_t         ctrl;
	logic             idle;
	logic             start, stop, out_free;
	logic [TOL_W-1:0] tolerance_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] eased_q;
	logic [OUT_W-1:0] eased_value;

	assign start      = item.valid && idle;
	assign item.ready = idle;
	assign out_free   = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOL_RESET;
		end else if (cfg_we) begin
			tolerance_q <= cfg_wdata;
		end
	end

	bz_seq #(
		.ITERATIONS (ITERATIONS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.stop     (stop),
		.out_free (out_free),
		.idle     (idle),
		.ctrl     (ctrl)
	);

	bz_dp #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk         (clk),
		.ctrl        (ctrl),
		.tolerance   (tolerance_q),
		.position    (item.position),
		.ctrl_one_x  (item.ctrl_one_x),
		.ctrl_one_y  (item.ctrl_one_y),
		.ctrl_two_x  (item.ctrl_two_x),
		.ctrl_two_y  (item.ctrl_two_y),
		.stop        (stop),
		.eased_value (eased_value)
	);

	// output register, frees the search for the next item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.result_en) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.result_en) begin
			eased_q <= eased_value;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.eased_value = eased_q;

endmodule

`default_nettype wire

FILE: rtl/bz_checker.sv
// ----------------------------------------------------------------------------
// bz_checker: port level checks for the bezier easing evaluator
// Watches the item and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bz_checker import bz_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_valid,
	input wire logic             item_ready,
	input wire logic             result_valid,
	input wire logic             result_ready,
	input wire logic [OUT_W-1:0] eased_value
);

	// a pending result is held until its transfer
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result valid dropped before transfer");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(eased_value))
		else $error("result payload changed while stalled");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> eased_value <= OUT_MAX)
		else $error("eased value above one");

	// the search keeps the item side closed while it runs
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready ##1 !item_ready)
		else $error("item accepted during a search");

endmodule

bind bezier_easing_bisection bz_checker u_bz_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.eased_value  (result.eased_value)
);

`default_nettype wire

FILE: verif/tb_bezier_easing_bisection.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_bezier_easing_bisection: self-checking bench for the bezier easing block
// A directed table walks the field extremes, positions above one and the
// saturating result. Random items then run under several tolerance settings
// with random gaps and stalls on both channels, including one long receiver
// hold-off. Every result is checked against its typed value or a bit-exact fixed point predictor.
// ----------------------------------------------------------------------------

module tb_bezier_easing_bisection;
	import bz_pkg::*;

	localparam int unsigned FB            = DEF_FRACTION_BITS;
	localparam int unsigned STEPS         = DEF_ITERATIONS;
	localparam logic [63:0] FX_ONE        = 64'd1 << FB;
	localparam int unsigned PHASES        = 6;
	localparam int unsigned PHASE_ITEMS   = 240;
	localparam int unsigned HOLD_CYCLES   = 3000;
	localparam int unsigned SETTLE_CYCLES = 11 * STEPS + 100;
	localparam int unsigned CYCLE_LIMIT   = 6_000_000;
	localparam logic        TYPED         = 1'b1;
	localparam logic        PREDICTED     = 1'b0;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic [CTRL_W-1:0] one_x;
		logic [CTRL_W-1:0] one_y;
		logic [CTRL_W-1:0] two_x;
		logic [CTRL_W-1:0] two_y;
	} easing_item_t;

	typedef struct packed {
		logic             typed;
		logic [OUT_W-1:0] eased;
		easing_item_t     item;
	} easing_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [TOL_W-1:0] cfg_wdata;

	bz_item_if   item_ch();
	bz_result_if result_ch();

	logic [OUT_W-1:0] eased_due [$];
	logic [TOL_W-1:0] tol_now = TOL_RESET;
	logic             tx_quiet = 1'b0;
	logic             rx_quiet = 1'b0;
	logic             rx_hold = 1'b0;
	int               mismatches = 0;
	int               results_checked = 0;
	int               items_sent = 0;
	int               directed_count = 0;
	longint           cycle_count = 0;

	bezier_easing_bisection #(
		.ITERATIONS(STEPS),
		.FRACTION_BITS(FB)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item(item_ch),
		.result(result_ch)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// (a*b) >> FB, rounded to nearest with halves up
	function automatic logic [63:0] fixed_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b} + (128'd1 << (FB - 1));
		return prod[FB +: 64];
	endfunction

	function automatic logic [63:0] bezier_coord(input logic [63:0] t, input logic [63:0] p1,
			input logic [63:0] p2);
		logic [63:0] u;
		u = (t <= FX_ONE) ? FX_ONE - t : 64'd0;
		return fixed_mul(fixed_mul(fixed_mul(u, u), t), p1) * 64'd3
			+ fixed_mul(fixed_mul(fixed_mul(u, t), t), p2) * 64'd3
			+ fixed_mul(fixed_mul(t, t), t);
	endfunction

	function automatic logic [63:0] ctrl_scaled(input logic [CTRL_W-1:0] c);
		return ((64'(c) << FB) + 64'd63) / 64'd127;
	endfunction

	function automatic logic [OUT_W-1:0] eased_of(input easing_item_t it,
			input logic [TOL_W-1:0] tol);
		logic [63:0] x, px1, py1, px2, py2, tol_fx;
		logic [63:0] lo, mid, hi, bl, bm, miss, y, half, rounded;
		logic        settled, lower;
		x   = 64'(it.position) << (FB - 16);
		px1 = ctrl_scaled(it.one_x);
		py1 = ctrl_scaled(it.one_y);
		px2 = ctrl_scaled(it.two_x);
		py2 = ctrl_scaled(it.two_y);
		if (FB >= 24) begin
			tol_fx = 64'(tol) << (FB - 24);
		end else begin
			tol_fx = 64'(tol) >> (24 - FB);
		end
		lo      = 64'd0;
		mid     = FX_ONE >> 1;
		hi      = FX_ONE;
		settled = 1'b0;
		for (int i = 0; i < STEPS && !settled; i++) begin
			bl   = bezier_coord(lo, px1, px2);
			bm   = bezier_coord(mid, px1, px2);
			miss = (x >= bm) ? x - bm : bm - x;
			if (miss < tol_fx) begin
				settled = 1'b1;
			end else begin
				// lower half only on a strict sign change between low and mid
				lower = (x > bl && x < bm) || (x < bl && x > bm);
				if (lower) begin
					hi  = mid;
					mid = (mid + lo) >> 1;
				end else begin
					lo  = mid;
					mid = (hi + mid) >> 1;
				end
			end
		end
		y       = bezier_coord(mid, py1, py2);
		half    = (64'd1 << (FB - 16)) >> 1;
		rounded = (y + half) >> (FB - 16);
		if (rounded > 64'(OUT_MAX)) begin
			return OUT_MAX;
		end
		return rounded[OUT_W-1:0];
	endfunction

	// ------------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------------

	task automatic flag_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic logic [CTRL_W-1:0] random_ctrl();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return '0;
		end else if (r == 1) begin
			return '1;
		end
		return CTRL_W'($urandom_range(0, 127));
	endfunction

	// called at a rising edge, returns at the edge of the transfer
	task automatic offer_item(input easing_item_t it, input logic typed,
			input logic [OUT_W-1:0] eased);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.position   <= it.position;
		item_ch.ctrl_one_x <= it.one_x;
		item_ch.ctrl_one_y <= it.one_y;
		item_ch.ctrl_two_x <= it.two_x;
		item_ch.ctrl_two_y <= it.two_y;
		do @(posedge clk); while (!item_ch.ready);
		eased_due.push_back(typed ? eased : eased_of(it, tol_now));
		items_sent++;
	endtask

	task automatic wait_drained();
		while (eased_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_tolerance(input logic [TOL_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we  <= 1'b0;
		tol_now = value;
	endtask

	// ------------------------------------------------------------------------
	// result side: random stalls, one long hold-off, checking
	// ------------------------------------------------------------------------

	initial begin : result_sink
		int stall;
		int held;
		logic [OUT_W-1:0] want;
		stall = 0;
		held  = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				results_checked++;
				if (eased_due.size() == 0) begin
					flag_mismatch($sformatf("result %0d with nothing pending",
						result_ch.eased_value));
				end else begin
					want = eased_due.pop_front();
					if (result_ch.eased_value !== want) begin
						flag_mismatch($sformatf("eased_value %0d, predicted %0d",
							result_ch.eased_value, want));
					end
				end
				stall = rx_quiet ? 0 : $urandom_range(0, 17);
			end
			if (rx_hold && held < HOLD_CYCLES) begin
				held++;
				result_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("no progress within %0d cycles", CYCLE_LIMIT);
		$display("bezier_easing_bisection test failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	initial begin : stimulus
		easing_row_t      directed [$];
		logic [TOL_W-1:0] settings [PHASES];
		easing_item_t     it;
		int               r;

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		item_ch.valid      = 1'b0;
		item_ch.position   = '0;
		item_ch.ctrl_one_x = '0;
		item_ch.ctrl_one_y = '0;
		item_ch.ctrl_two_x = '0;
		item_ch.ctrl_two_y = '0;

		// typed, eased, position, one_x, one_y, two_x, two_y
		// far above one the search ends at t just under one, so y rounds to one
		directed.push_back({TYPED, OUT_MAX, 17'd131071, 7'd0, 7'd0, 7'd0, 7'd0});
		directed.push_back({TYPED, OUT_MAX, 17'd131071, 7'd127, 7'd127, 7'd127, 7'd127});
		directed.push_back({TYPED, OUT_MAX, 17'd131071, 7'd127, 7'd0, 7'd0, 7'd127});
		directed.push_back({PREDICTED, 17'd0, 17'd0, 7'd0, 7'd0, 7'd0, 7'd0});
		directed.push_back({PREDICTED, 17'd0, 17'd0, 7'd127, 7'd127, 7'd127, 7'd127});
		directed.push_back({PREDICTED, 17'd0, 17'd65536, 7'd0, 7'd0, 7'd0, 7'd0});
		directed.push_back({PREDICTED, 17'd0, 17'd65536, 7'd127, 7'd127, 7'd127, 7'd127});
		directed.push_back({PREDICTED, 17'd0, 17'd65537, 7'd64, 7'd0, 7'd64, 7'd127});
		directed.push_back({PREDICTED, 17'd0, 17'd32768, 7'd0, 7'd0, 7'd127, 7'd127});
		directed.push_back({PREDICTED, 17'd0, 17'd32768, 7'd127, 7'd127, 7'd0, 7'd0});
		directed.push_back({PREDICTED, 17'd0, 17'd32768, 7'd127, 7'd0, 7'd0, 7'd127});
		directed.push_back({PREDICTED, 17'd0, 17'd16384, 7'd42, 7'd0, 7'd58, 7'd127});
		directed.push_back({PREDICTED, 17'd0, 17'd49152, 7'd107, 7'd0, 7'd127, 7'd127});
		directed.push_back({PREDICTED, 17'd0, 17'h0AAAA, 7'h55, 7'h2A, 7'h55, 7'h2A});
		directed.push_back({PREDICTED, 17'd0, 17'h15555, 7'h2A, 7'h55, 7'h2A, 7'h55});
		directed.push_back({PREDICTED, 17'd0, 17'd1, 7'd127, 7'd0, 7'd0, 7'd127});
		directed.push_back({PREDICTED, 17'd0, 17'd65535, 7'd0, 7'd127, 7'd127, 7'd0});
		directed.push_back({PREDICTED, 17'd0, 17'd100000, 7'd10, 7'd120, 7'd90, 7'd5});
		directed.push_back({PREDICTED, 17'd0, 17'd12345, 7'd1, 7'd126, 7'd126, 7'd1});
		directed.push_back({PREDICTED, 17'd0, 17'd65536, 7'd64, 7'd64, 7'd64, 7'd64});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows run at the reset tolerance
		foreach (directed[k]) begin
			offer_item(directed[k].item, directed[k].typed, directed[k].eased);
		end
		directed_count = directed.size();

		settings = '{16'd0, 16'hFFFF, 16'($urandom_range(2, 65534)), 16'd1,
			16'($urandom_range(2, 65534)), TOL_RESET};

		for (int p = 0; p < PHASES; p++) begin
			item_ch.valid <= 1'b0;
			wait_drained();
			write_tolerance(settings[p]);
			tx_quiet = (p == 1 || p == 2);
			rx_quiet = (p == 1 || p == 4);
			// sender keeps offering back to back while the receiver holds off
			if (p == 2) begin
				rx_hold = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					it.position = '0;
				end else if (r < 10) begin
					it.position = 17'd65536;
				end else if (r < 18) begin
					it.position = POS_W'($urandom_range(65537, 131071));
				end else if (r < 23) begin
					it.position = POS_W'($urandom_range(0, 255));
				end else begin
					it.position = POS_W'($urandom_range(0, 65536));
				end
				it.one_x = random_ctrl();
				it.one_y = random_ctrl();
				it.two_x = random_ctrl();
				it.two_y = random_ctrl();
				offer_item(it, PREDICTED, '0);
			end
		end

		item_ch.valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d items sent (%0d from the table), %0d results checked in %0d cycles",
			items_sent, directed_count, results_checked, cycle_count);
		$display("tolerances: reset, 0, max, 1 and two random; one %0d cycle receiver hold",
			HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("bezier_easing_bisection test passed");
		end else begin
			$display("bezier_easing_bisection test failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/bz_pkg.sv
rtl/bz_if.sv
rtl/bz_mul.sv
rtl/bz_seq.sv
rtl/bz_dp.sv
rtl/bezier_easing_bisection.sv
rtl/bz_checker.sv
verif/tb_bezier_easing_bisection.sv
